### src/wec_pkg.sv
// wec_pkg: shared types and constants for the log-entry checker.
// Item and result structs, status codes, header layout and the CRC-32C byte step.
// Used by every module in src.
package wec_pkg;

	localparam int unsigned HEADER_BYTES = 32;
	localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

	localparam int unsigned OFS_ENTRY_LEN = 16;
	localparam int unsigned OFS_VALUE_LEN = 20;
	localparam int unsigned OFS_KEY_LEN   = 24;
	localparam int unsigned OFS_FLAGS     = 26;
	localparam int unsigned OFS_CRC       = 28;

	localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
	localparam logic [31:0] MAX_LEN_RST  = 32'd16777216;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_LEN   = 2'd1,
		STATUS_BAD_CRC   = 2'd2,
		STATUS_SIZE_MISM = 2'd3
	} wec_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} wec_item_t;

	typedef struct packed {
		wec_status_t status;
		logic [63:0] sequence_res;
		logic [63:0] key_fingerprint;
		logic [15:0] key_length;
		logic [31:0] value_length;
		logic [15:0] entry_flags;
	} wec_result_t;

	// one byte of reflected CRC-32C, bit at a time
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### src/wec_entry_core.sv
// wec_entry_core: per-entry state (CRC, saturating byte count, header bytes)
// and the result evaluation for the item held in the input register.
// Depends on wec_pkg.
module wec_entry_core import wec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  wec_item_t   item_s1,
	input  logic [31:0] max_entry_bytes,
	output wec_result_t result
);

	logic [31:0] crc_q;
	logic [31:0] count_q;
	logic [7:0]  hdr_q    [HEADER_BYTES];
	logic [7:0]  hdr_next [HEADER_BYTES];

	logic        in_hdr;
	logic        in_crc_field;
	logic [7:0]  fed;
	logic [31:0] crc_next;
	logic [31:0] count_next;

	logic [31:0] entry_len;
	logic [31:0] value_len;
	logic [15:0] key_len;
	logic [31:0] stored_crc;
	logic [32:0] expected;
	logic        len_bad;

	assign in_hdr       = (count_q[31:HDR_IDX_W] == '0);
	assign in_crc_field = in_hdr && (count_q[HDR_IDX_W-1:0] >= HDR_IDX_W'(OFS_CRC));
	assign fed          = in_crc_field ? 8'd0 : item_s1.data_byte;
	assign crc_next     = crc32c_byte(crc_q, fed);
	assign count_next   = (count_q == '1) ? count_q : count_q + 32'd1;

	// header view including the byte being written now
	always_comb begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			hdr_next[i] = hdr_q[i];
		end
		if (in_hdr) begin
			hdr_next[count_q[HDR_IDX_W-1:0]] = item_s1.data_byte;
		end
	end

	assign entry_len  = {hdr_next[OFS_ENTRY_LEN+3], hdr_next[OFS_ENTRY_LEN+2],
	                     hdr_next[OFS_ENTRY_LEN+1], hdr_next[OFS_ENTRY_LEN]};
	assign value_len  = {hdr_next[OFS_VALUE_LEN+3], hdr_next[OFS_VALUE_LEN+2],
	                     hdr_next[OFS_VALUE_LEN+1], hdr_next[OFS_VALUE_LEN]};
	assign key_len    = {hdr_next[OFS_KEY_LEN+1], hdr_next[OFS_KEY_LEN]};
	assign stored_crc = {hdr_next[OFS_CRC+3], hdr_next[OFS_CRC+2],
	                     hdr_next[OFS_CRC+1], hdr_next[OFS_CRC]};
	assign expected   = 33'(HEADER_BYTES) + {17'd0, key_len} + {1'b0, value_len};

	assign len_bad = (entry_len < 32'(HEADER_BYTES)) || (entry_len > max_entry_bytes)
	                 || (expected != {1'b0, entry_len});

	always_comb begin
		if (count_next < 32'(HEADER_BYTES)) begin
			result        = '0;
			result.status = STATUS_SIZE_MISM;
		end else begin
			if (len_bad) begin
				result.status = STATUS_BAD_LEN;
			end else if (count_next != entry_len) begin
				result.status = STATUS_SIZE_MISM;
			end else if (~crc_next != stored_crc) begin
				result.status = STATUS_BAD_CRC;
			end else begin
				result.status = STATUS_OK;
			end
			result.sequence_res    = {hdr_next[7], hdr_next[6], hdr_next[5], hdr_next[4],
			                          hdr_next[3], hdr_next[2], hdr_next[1], hdr_next[0]};
			result.key_fingerprint = {hdr_next[15], hdr_next[14], hdr_next[13], hdr_next[12],
			                          hdr_next[11], hdr_next[10], hdr_next[9], hdr_next[8]};
			result.key_length      = key_len;
			result.value_length    = value_len;
			result.entry_flags     = {hdr_next[OFS_FLAGS+1], hdr_next[OFS_FLAGS]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= '0;
		end else if (step) begin
			if (item_s1.last_byte) begin
				crc_q   <= CRC_INIT;
				count_q <= '0;
			end else begin
				crc_q   <= crc_next;
				count_q <= count_next;
			end
		end
	end

	// header bytes: no reset, a short entry never exposes them
	always_ff @(posedge clk) begin
		if (step && in_hdr) begin
			hdr_q[count_q[HDR_IDX_W-1:0]] <= item_s1.data_byte;
		end
	end

endmodule

### src/wal_entry_checker.sv
// wal_entry_checker: top level of the log-entry checker.
// Input register, entry core and result register. Depends on wec_pkg and wec_entry_core.
//
//  channel   signals                               direction  holds
//  item      item_valid / item_ready / item        in         one entry byte + last mark
//  result    result_valid / result_ready / result  out        status and header fields
//  cfg       cfg_valid / cfg_ready / cfg_data      in         max_entry_bytes
//
// One item per cycle unless a last byte waits on a stalled result; a result is offered
// after its last byte is taken, through the input register, then the result register.
// CRC update, count and checks sit between those two registers.
// Reset clears the CRC, count, config and valid flags; header bytes are left as they were.
// A waiting result stalls only last bytes behind it; other bytes keep flowing.
module wal_entry_checker import wec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  wec_item_t   item,
	output logic        result_valid,
	input  logic        result_ready,
	output wec_result_t result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic        valid_s1;
	wec_item_t   item_s1;
	logic        out_free;
	logic        step;
	logic [31:0] max_len_q;
	wec_result_t res_comb;

	assign out_free   = !result_valid || result_ready;
	assign step       = valid_s1 && (!item_s1.last_byte || out_free);
	assign item_ready = !valid_s1 || step;
	assign cfg_ready  = 1'b1;

	wec_entry_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.item_s1         (item_s1),
		.max_entry_bytes (max_len_q),
		.result          (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
			max_len_q    <= MAX_LEN_RST;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (step && item_s1.last_byte) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (step && item_s1.last_byte) begin
			result <= res_comb;
		end
	end

endmodule

### src/wec_checker.sv
// wec_checker: port-level assertions for wal_entry_checker, bound to the top level.
// Depends on wec_pkg.
module wec_checker import wec_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input wec_result_t result,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input only backs up behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("item stalled without a stalled result");

	// a fresh result came from a cycle where the input side was moving
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_ready))
		else $error("result appeared while input side was blocked");

	// passing the length check means header+key+value fits in 32 bits
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == STATUS_OK || result.status == STATUS_BAD_CRC)
		|-> (33'(HEADER_BYTES) + {17'd0, result.key_length} + {1'b0, result.value_length})
		    <= 33'h0_FFFF_FFFF)
		else $error("length check passed on an oversized entry");

	// config never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind wal_entry_checker wec_checker u_wec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
